// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled in reset.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dc offset checker: property failed");

// Same-cycle implication.
`define CHK_IMPL(label, clk, rst, ante, cons) \
   `CHK_ASSERT(label, clk, rst, (ante) |-> (cons))

// Next-cycle implication.
`define CHK_NEXT(label, clk, rst, ante, cons) \
   `CHK_ASSERT(label, clk, rst, (ante) |=> (cons))

`endif

// ===== design/dcorn_pkg.sv =====
`default_nettype none

package dcorn_pkg;

   localparam int DEF_MAX_RANGE_LENGTH = 65536;
   localparam int DEF_OFFSET_FRAC_BITS = 8;
   localparam int DEF_GAIN_FRAC_BITS   = 16;

   localparam int SAMPLE_W     = 16;
   localparam int OFFSET_OUT_W = 24;

   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_APPLY   = 1'b1;

   localparam logic WIDTH_16 = 1'b1;

   typedef struct packed {
      logic accum;
      logic capture;
      logic div_start;
      logic div_sel_gain;
      logic store_q;
      logic store_g;
      logic gain_zero;
      logic mul;
      logic rnd;
      logic load_report;
      logic load_apply;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic peak_pos;
   } status_type;

endpackage

`default_nettype wire

// ===== design/dcorn_if.sv =====
`default_nettype none

interface dcorn_req_if import dcorn_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, output operation, output sample, output last, input ready);
   modport sink   (input valid, input operation, input sample, input last, output ready);
endinterface

interface dcorn_rsp_if import dcorn_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           is_summary;
   logic signed [SAMPLE_W-1:0]     sample_out;
   logic signed [OFFSET_OUT_W-1:0] offset_out;
   logic                           skipped;

   modport source (output valid, output is_summary, output sample_out, output offset_out,
                   output skipped, input ready);
   modport sink   (input valid, input is_summary, input sample_out, input offset_out,
                   input skipped, output ready);
endinterface

interface dcorn_csr_if ();
   logic valid;
   logic ready;
   logic sample_width;

   modport source (output valid, output sample_width, input ready);
   modport sink   (input valid, input sample_width, output ready);
endinterface

`default_nettype wire

// ===== design/dcorn_div.sv =====
`default_nettype none

module dcorn_div #(
   parameter int D_W = 41,
   parameter int V_W = 26
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [D_W-1:0] dividend,
   input  wire logic [V_W-1:0] divisor,
   output logic                done,
   output logic [D_W-1:0]      quotient
);

   localparam int C_W = $clog2(D_W + 1);

   logic [D_W-1:0] quo_ff, quo_in;
   logic [V_W-1:0] rem_ff, rem_in;
   logic [V_W-1:0] dvs_ff, dvs_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [V_W:0]   trial;

   // restoring division, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[D_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = C_W'(D_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = V_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[D_W-2:0], 1'b1};
         end else begin
            rem_in = trial[V_W-1:0];
            quo_in = {quo_ff[D_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - C_W'(1);
         if (cnt_ff == C_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== design/dcorn_ctrl.sv =====
`default_nettype none

module dcorn_ctrl import dcorn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_operation,
   input  wire logic       req_last,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_QSTART = 9'b000000010,
      S_QWAIT  = 9'b000000100,
      S_GSTART = 9'b000001000,
      S_GWAIT  = 9'b000010000,
      S_REPORT = 9'b000100000,
      S_MUL    = 9'b001000000,
      S_RND    = 9'b010000000,
      S_APPLY  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_MEASURE) begin
                  cmd.accum = 1'b1;
                  if (req_last) state_in = S_QSTART;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = S_MUL;
               end
            end
         end
         S_QSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_QWAIT;
         end
         S_QWAIT: begin
            if (status.div_done) begin
               cmd.store_q = 1'b1;
               state_in    = S_GSTART;
            end
         end
         S_GSTART: begin
            if (status.peak_pos) begin
               cmd.div_start    = 1'b1;
               cmd.div_sel_gain = 1'b1;
               state_in         = S_GWAIT;
            end else begin
               cmd.gain_zero = 1'b1;
               state_in      = S_REPORT;
            end
         end
         S_GWAIT: begin
            if (status.div_done) begin
               cmd.store_g = 1'b1;
               state_in    = S_REPORT;
            end
         end
         S_REPORT: begin
            if (slot_free) begin
               cmd.load_report = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_RND;
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (slot_free) begin
               cmd.load_apply = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold the result until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_report || cmd.load_apply) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/dcorn_datapath.sv =====
`default_nettype none

module dcorn_datapath import dcorn_pkg::*; #(
   parameter int MAX_RANGE_LENGTH = DEF_MAX_RANGE_LENGTH,
   parameter int OFFSET_FRAC_BITS = DEF_OFFSET_FRAC_BITS,
   parameter int GAIN_FRAC_BITS   = DEF_GAIN_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   input  wire logic                       csr_write,
   input  wire logic                       csr_sample_width,
   input  wire logic [SAMPLE_W-1:0]        req_sample,
   output logic                            rsp_is_summary,
   output logic signed [SAMPLE_W-1:0]      rsp_sample_out,
   output logic signed [OFFSET_OUT_W-1:0]  rsp_offset_out,
   output logic                            rsp_skipped
);

   localparam int OF     = OFFSET_FRAC_BITS;
   localparam int GF     = GAIN_FRAC_BITS;
   localparam int CNT_W  = $clog2(MAX_RANGE_LENGTH + 1);
   localparam int SUM_W  = CNT_W + SAMPLE_W;
   localparam int SMP_W  = SAMPLE_W + 1;
   localparam int Q_W    = OF + SAMPLE_W + 1;
   localparam int P_W    = OF + SAMPLE_W + 2;
   localparam int MAG_W  = SUM_W + OF;
   localparam int SH     = OF + GF;
   localparam int NUM_W  = SH + SAMPLE_W + 1;
   localparam int D_W    = (MAG_W > NUM_W) ? MAG_W : NUM_W;
   localparam int V_W    = (CNT_W > P_W) ? CNT_W : P_W;
   localparam int G_W    = 8 + GF;
   localparam int PROD_W = P_W + G_W + 1;
   localparam int RND_W  = PROD_W - SH;
   localparam int QX_W   = (Q_W > OFFSET_OUT_W) ? Q_W : OFFSET_OUT_W;

   localparam logic signed [SMP_W-1:0] HI_RST = SMP_W'(-(2 ** (SAMPLE_W - 1)));
   localparam logic signed [SMP_W-1:0] LO_RST = SMP_W'(2 ** (SAMPLE_W - 1));
   localparam logic [G_W-1:0] GAIN_ONE = G_W'(1) << GF;
   localparam logic [G_W-1:0] GAIN_MAX = '1;
   localparam logic signed [QX_W-1:0] REP_MAX = QX_W'(24'sh7FFFFF);
   localparam logic signed [QX_W-1:0] REP_MIN = QX_W'(24'sh800000);

   logic                       width_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]           cnt_ff;
   logic signed [SMP_W-1:0]    hi_ff, lo_ff;
   logic signed [Q_W-1:0]      offset_ff;
   logic [G_W-1:0]             gain_ff;
   logic                       skip_ff;
   logic signed [SAMPLE_W-1:0] smp_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic [RND_W-1:0]           rnd_ff;
   logic                       neg_ff;
   logic                       is_summary_ff, skipped_ff;
   logic signed [SAMPLE_W-1:0] sample_out_ff;
   logic signed [OFFSET_OUT_W-1:0] offset_out_ff;

   logic signed [SAMPLE_W-1:0] s_ext;
   logic                       cnt_full;
   logic [SUM_W-1:0]           sum_mag;
   logic [MAG_W-1:0]           q_dvd;
   logic signed [P_W-1:0]      hi_term, lo_term, peak;
   logic [P_W-1:0]             peak_u;
   logic [NUM_W-1:0]           g_dvd;
   logic [D_W-1:0]             div_dvd, quotient;
   logic [V_W-1:0]             div_dvs;
   logic                       div_done;
   logic [Q_W-1:0]             q_mag;
   logic signed [P_W-1:0]      a_term;
   logic signed [G_W:0]        gain_s;
   logic [PROD_W-1:0]          prod_mag;
   logic [RND_W-1:0]           lim_pos, lim_neg, mag_c;
   logic signed [SAMPLE_W-1:0] r_app;
   logic signed [QX_W-1:0]     qx, qx_c;

   assign s_ext = (width_ff == WIDTH_16) ? signed'(req_sample)
                                         : {{8{req_sample[7]}}, req_sample[7:0]};
   assign cnt_full = (cnt_ff >= CNT_W'(MAX_RANGE_LENGTH));

   // offset division operands
   assign sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign q_dvd   = {sum_mag, {OF{1'b0}}};

   // peak and gain division operands, from the stored offset
   assign hi_term = (P_W'(hi_ff) <<< OF) + P_W'(offset_ff);
   assign lo_term = -((P_W'(lo_ff) <<< OF) + P_W'(offset_ff));
   assign peak    = (hi_term > lo_term) ? hi_term : lo_term;
   assign peak_u  = peak;
   assign g_dvd   = ((width_ff == WIDTH_16) ? (NUM_W'(1) << (SAMPLE_W - 1 + SH))
                                            : (NUM_W'(1) << (7 + SH)))
                    + NUM_W'(peak_u >> 1);

   assign div_dvd = cmd.div_sel_gain ? D_W'(g_dvd) : D_W'(q_dvd);
   assign div_dvs = cmd.div_sel_gain ? V_W'(peak_u) : V_W'(cnt_ff);

   dcorn_div #(
      .D_W (D_W),
      .V_W (V_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.div_done = div_done;
   assign status.peak_pos = !peak[P_W-1] && (peak != '0);

   assign q_mag = quotient[Q_W-1:0];

   // apply path
   assign a_term   = (P_W'(smp_ff) <<< OF) + P_W'(offset_ff);
   assign gain_s   = signed'({1'b0, gain_ff});
   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign lim_pos  = (width_ff == WIDTH_16) ? RND_W'(2 ** (SAMPLE_W - 1) - 1) : RND_W'(127);
   assign lim_neg  = (width_ff == WIDTH_16) ? RND_W'(2 ** (SAMPLE_W - 1)) : RND_W'(128);

   always_comb begin
      if (neg_ff) begin
         mag_c = (rnd_ff > lim_neg) ? lim_neg : rnd_ff;
         r_app = -signed'(SAMPLE_W'(mag_c));
      end else begin
         mag_c = (rnd_ff > lim_pos) ? lim_pos : rnd_ff;
         r_app = signed'(SAMPLE_W'(mag_c));
      end
      if (skip_ff) r_app = smp_ff;
   end

   // saturate the reported offset to the output field
   assign qx = QX_W'(offset_ff);
   assign qx_c = (qx > REP_MAX) ? REP_MAX : ((qx < REP_MIN) ? REP_MIN : qx);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_16;
         sum_ff    <= '0;
         cnt_ff    <= '0;
         hi_ff     <= HI_RST;
         lo_ff     <= LO_RST;
         offset_ff <= '0;
         gain_ff   <= GAIN_ONE;
         skip_ff   <= 1'b1;
      end else begin
         if (csr_write) width_ff <= csr_sample_width;
         if (cmd.accum && !cnt_full) begin
            sum_ff <= sum_ff + SUM_W'(s_ext);
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (SMP_W'(s_ext) > hi_ff) hi_ff <= SMP_W'(s_ext);
            if (SMP_W'(s_ext) < lo_ff) lo_ff <= SMP_W'(s_ext);
         end
         if (cmd.load_report) begin
            sum_ff <= '0;
            cnt_ff <= '0;
            hi_ff  <= HI_RST;
            lo_ff  <= LO_RST;
         end
         if (cmd.store_q) begin
            offset_ff <= sum_ff[SUM_W-1] ? signed'(q_mag) : -signed'(q_mag);
            skip_ff   <= ((q_mag >> OF) == '0);
         end
         if (cmd.store_g) gain_ff <= (quotient > D_W'(GAIN_MAX)) ? GAIN_MAX : quotient[G_W-1:0];
         if (cmd.gain_zero) gain_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) smp_ff <= s_ext;
      if (cmd.mul) prod_ff <= PROD_W'(a_term * gain_s);
      if (cmd.rnd) begin
         rnd_ff <= RND_W'((prod_mag + (PROD_W'(1) << (SH - 1))) >> SH);
         neg_ff <= prod_ff[PROD_W-1];
      end
      if (cmd.load_report) begin
         is_summary_ff <= 1'b1;
         sample_out_ff <= '0;
         offset_out_ff <= qx_c[OFFSET_OUT_W-1:0];
         skipped_ff    <= skip_ff;
      end else if (cmd.load_apply) begin
         is_summary_ff <= 1'b0;
         sample_out_ff <= r_app;
         offset_out_ff <= '0;
         skipped_ff    <= skip_ff;
      end
   end

   assign rsp_is_summary = is_summary_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_offset_out = offset_out_ff;
   assign rsp_skipped    = skipped_ff;

endmodule

`default_nettype wire

// ===== design/dc_offset_remove_normalize_top.sv =====
`default_nettype none

// DC offset removal with peak normalization over a block of signed 8- or 16-bit
// samples, in two passes: measure transactions (operation 0) accumulate sum, count,
// max and min; the one marked last triggers the offset and gain computation and
// returns one summary transaction. Apply transactions (operation 1) each return one
// corrected sample. A measure transaction that is not last leaves the controller idle and
// ready for the next request. The last one holds off new requests for the offset
// division and, if the peak is positive, the gain division on the shared radix-2
// divider, one quotient bit per cycle over D_W bits (41 at the default parameters).
// An apply passes capture, multiply, round, and load into the free output register,
// which holds a finished result while the next request is accepted.

module dc_offset_remove_normalize_top import dcorn_pkg::*; #(
   parameter int MAX_RANGE_LENGTH = DEF_MAX_RANGE_LENGTH,
   parameter int OFFSET_FRAC_BITS = DEF_OFFSET_FRAC_BITS,
   parameter int GAIN_FRAC_BITS   = DEF_GAIN_FRAC_BITS
) (
   input wire logic     clock,
   input wire logic     reset,
   dcorn_req_if.sink    req_ch,
   dcorn_rsp_if.source  rsp_ch,
   dcorn_csr_if.sink    csr_ch
);

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   dcorn_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_last      (req_ch.last),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .status        (status),
      .cmd           (cmd)
   );

   dcorn_datapath #(
      .MAX_RANGE_LENGTH (MAX_RANGE_LENGTH),
      .OFFSET_FRAC_BITS (OFFSET_FRAC_BITS),
      .GAIN_FRAC_BITS   (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_ch.valid),
      .csr_sample_width (csr_ch.sample_width),
      .req_sample       (req_ch.sample),
      .rsp_is_summary   (rsp_ch.is_summary),
      .rsp_sample_out   (rsp_ch.sample_out),
      .rsp_offset_out   (rsp_ch.offset_out),
      .rsp_skipped      (rsp_ch.skipped)
   );

endmodule

`default_nettype wire

// ===== design/dcorn_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module dcorn_checker import dcorn_pkg::*; (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           req_operation,
   input wire logic                           req_last,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_is_summary,
   input wire logic signed [SAMPLE_W-1:0]     rsp_sample_out,
   input wire logic signed [OFFSET_OUT_W-1:0] rsp_offset_out
);

   logic measure_take;

   assign measure_take = req_valid && req_ready && (req_operation == OP_MEASURE);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_NEXT(a_no_rsp_mid_block, clock, reset, measure_take && !req_last && !rsp_valid, !rsp_valid)
   `CHK_NEXT(a_stall_on_close, clock, reset, measure_take && req_last, !req_ready)
   `CHK_IMPL(a_report_no_sample, clock, reset, rsp_valid && rsp_is_summary, rsp_sample_out == '0)
   `CHK_IMPL(a_apply_no_offset, clock, reset, rsp_valid && !rsp_is_summary, rsp_offset_out == '0)

endmodule

bind dc_offset_remove_normalize_top dcorn_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_operation  (req_ch.operation),
   .req_last       (req_ch.last),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_is_summary (rsp_ch.is_summary),
   .rsp_sample_out (rsp_ch.sample_out),
   .rsp_offset_out (rsp_ch.offset_out)
);

`default_nettype wire

// ===== sim/dc_offset_remove_normalize_top_tb.sv =====
`timescale 1ns / 1ps

module dc_offset_remove_normalize_top_tb;
   import dcorn_pkg::*;

   typedef struct {
      logic                       operation;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } sample_item_t;

   typedef struct {
      logic                           is_summary;
      logic signed [SAMPLE_W-1:0]     sample_out;
      logic signed [OFFSET_OUT_W-1:0] offset_out;
      logic                           skipped;
   } corrected_t;

   localparam longint ONE_OFF  = 64'sd1 <<< DEF_OFFSET_FRAC_BITS;
   localparam longint GAIN_SAT = (64'sd1 <<< (8 + DEF_GAIN_FRAC_BITS)) - 1;
   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     SETTLE_CYCLES  = 150;
   localparam int     LONG_HOLD      = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dcorn_req_if req_ch ();
   dcorn_rsp_if rsp_ch ();
   dcorn_csr_if csr_ch ();

   dc_offset_remove_normalize_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   sample_item_t pending_samples[$];
   corrected_t   expected_results[$];
   int           error_count = 0;
   int           idle_cycles = 0;
   bit           bursty = 1'b1;
   bit           long_hold_request = 1'b0;

   // shadow of the block's state
   logic   width16 = WIDTH_16;
   longint acc_sum, acc_count, acc_high, acc_low;
   longint offset_q, gain_q;
   bit     skip_samples;

   function automatic void clear_block_stats();
      acc_sum   = 0;
      acc_count = 0;
      acc_high  = -32768;
      acc_low   = 32768;
   endfunction

   function automatic void reset_shadow();
      clear_block_stats();
      offset_q     = 0;
      gain_q       = 64'sd1 <<< DEF_GAIN_FRAC_BITS;
      skip_samples = 1'b1;
   endfunction

   function automatic void predict_correction(sample_item_t it);
      longint     fs, s, hi, lo, peak, v, mag, r, rep;
      corrected_t res;
      fs = width16 ? 32768 : 128;
      s  = width16 ? longint'(it.sample) : longint'($signed(it.sample[7:0]));
      if (it.operation == OP_MEASURE) begin
         if (acc_count < DEF_MAX_RANGE_LENGTH) begin
            acc_sum += s;
            acc_count++;
            if (s > acc_high) acc_high = s;
            if (s < acc_low) acc_low = s;
         end
         if (!it.last) return;
         offset_q = (acc_count > 0) ? (-acc_sum * ONE_OFF) / acc_count : 0;
         skip_samples = (offset_q < ONE_OFF) && (offset_q > -ONE_OFF);
         hi   = acc_high * ONE_OFF + offset_q;
         lo   = -(acc_low * ONE_OFF + offset_q);
         peak = (hi > lo) ? hi : lo;
         if (peak <= 0) gain_q = 0;
         else begin
            gain_q = ((fs <<< (DEF_OFFSET_FRAC_BITS + DEF_GAIN_FRAC_BITS)) + peak / 2) / peak;
            if (gain_q > GAIN_SAT) gain_q = GAIN_SAT;
         end
         rep = offset_q;
         if (rep > 8388607) rep = 8388607;
         if (rep < -8388608) rep = -8388608;
         res.is_summary = 1'b1;
         res.sample_out = '0;
         res.offset_out = rep[OFFSET_OUT_W-1:0];
         res.skipped    = skip_samples;
         clear_block_stats();
      end else begin
         r = s;
         if (!skip_samples) begin
            v   = (s * ONE_OFF + offset_q) * gain_q;
            mag = ((v < 0 ? -v : v) + (64'sd1 <<< (DEF_OFFSET_FRAC_BITS +
                   DEF_GAIN_FRAC_BITS - 1))) >>> (DEF_OFFSET_FRAC_BITS + DEF_GAIN_FRAC_BITS);
            r = (v < 0) ? -mag : mag;
            if (r > fs - 1) r = fs - 1;
            if (r < -fs) r = -fs;
         end
         res.is_summary = 1'b0;
         res.sample_out = r[SAMPLE_W-1:0];
         res.offset_out = '0;
         res.skipped    = skip_samples;
      end
      expected_results.push_back(res);
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!bursty || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // driver: present queued transactions, predict on acceptance
   int send_gap = 0;
   always @(posedge clock) begin
      sample_item_t it;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            it.operation = req_ch.operation;
            it.sample    = req_ch.sample;
            it.last      = req_ch.last;
            predict_correction(it);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the offered transaction
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            it = pending_samples.pop_front();
            req_ch.operation <= it.operation;
            req_ch.sample    <= it.sample;
            req_ch.last      <= it.last;
            req_ch.valid     <= 1'b1;
            send_gap = pick_gap();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor: random backpressure and compare
   int hold_left = 0;
   always @(posedge clock) begin
      corrected_t want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction summary=%0b sample=%0d offset=%0d",
                        $time, rsp_ch.is_summary, rsp_ch.sample_out, rsp_ch.offset_out);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.is_summary !== want.is_summary) begin
                  $display("%0t: is_summary expected %0b actual %0b",
                           $time, want.is_summary, rsp_ch.is_summary);
                  error_count++;
               end
               if (rsp_ch.sample_out !== want.sample_out) begin
                  $display("%0t: sample_out expected %0d actual %0d",
                           $time, want.sample_out, rsp_ch.sample_out);
                  error_count++;
               end
               if (rsp_ch.offset_out !== want.offset_out) begin
                  $display("%0t: offset_out expected %0d actual %0d",
                           $time, want.offset_out, rsp_ch.offset_out);
                  error_count++;
               end
               if (rsp_ch.skipped !== want.skipped) begin
                  $display("%0t: skipped expected %0b actual %0b",
                           $time, want.skipped, rsp_ch.skipped);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (pick_gap() == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int center, spread;
      if ($urandom_range(0, 3) == 0) return SAMPLE_W'($urandom);
      center = int'($urandom_range(0, 4000)) - 2000;
      spread = $urandom_range(1, 3000);
      return SAMPLE_W'(center + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   task automatic add_item(logic op, logic signed [SAMPLE_W-1:0] smp, logic lst);
      sample_item_t it;
      it.operation = op;
      it.sample    = smp;
      it.last      = lst;
      pending_samples.push_back(it);
   endtask

   task automatic add_block(int measure_len, int apply_len);
      for (int i = 0; i < measure_len; i++)
         add_item(OP_MEASURE, random_sample(), i == measure_len - 1);
      for (int i = 0; i < apply_len; i++)
         add_item(OP_APPLY, random_sample(), $urandom_range(0, 9) == 0);
   endtask

   task automatic add_random_phase(int count);
      int made;
      made = 0;
      // leading apply items run with whatever the previous phase measured
      for (int i = 0; i < 4; i++) add_item(OP_APPLY, random_sample(), 1'b0);
      while (made < count) begin
         int m, a;
         if ($urandom_range(0, 9) == 0) begin
            // stray transaction
            add_item(1'($urandom_range(0, 1)), SAMPLE_W'($urandom),
                     1'($urandom_range(0, 1)));
            made++;
         end else begin
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            a = $urandom_range(1, 16);
            add_block(m, a);
            made += m + a;
         end
      end
      // end on a measure so the next width applies to a fresh offset
      add_block($urandom_range(2, 8), 0);
   endtask

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sample_width(logic w);
      csr_ch.sample_width <= w;
      csr_ch.valid        <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      width16 = w;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      req_ch.valid        = 1'b0;
      req_ch.operation    = OP_MEASURE;
      req_ch.sample       = '0;
      req_ch.last         = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.sample_width = WIDTH_16;
      reset_shadow();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // apply before any measure passes samples through
      add_item(OP_APPLY, 16'sh7FFF, 1'b0);
      add_item(OP_APPLY, -16'sh8000, 1'b1);
      // extremes of the field
      add_item(OP_MEASURE, 16'sh7FFF, 1'b0);
      add_item(OP_MEASURE, -16'sh8000, 1'b0);
      add_item(OP_MEASURE, 16'sh7FFF, 1'b0);
      add_item(OP_MEASURE, 16'sh0000, 1'b1);
      add_item(OP_APPLY, 16'sh7FFF, 1'b0);
      add_item(OP_APPLY, -16'sh8000, 1'b0);
      add_item(OP_APPLY, 16'sh0000, 1'b1);
      // tiny mean, skipped
      add_item(OP_MEASURE, 16'sh0001, 1'b0);
      add_item(OP_MEASURE, 16'sh0000, 1'b0);
      add_item(OP_MEASURE, -16'sh0001, 1'b1);
      add_item(OP_APPLY, 16'sh1234, 1'b0);
      // flat block gives zero peak
      add_item(OP_MEASURE, 16'sh0005, 1'b0);
      add_item(OP_MEASURE, 16'sh0005, 1'b1);
      add_item(OP_APPLY, 16'sh0005, 1'b0);
      add_item(OP_APPLY, -16'sh7000, 1'b0);
      // one-sample block
      add_item(OP_MEASURE, -16'sh0400, 1'b1);
      add_item(OP_APPLY, 16'shFFFF, 1'b0);
      add_item(OP_APPLY, 16'sh00FF, 1'b0);
      wait_drained();

      write_sample_width(1'b0);
      add_item(OP_MEASURE, 16'sh7F80, 1'b0);
      add_item(OP_MEASURE, 16'sh807F, 1'b1);
      add_item(OP_APPLY, 16'sh007F, 1'b0);
      add_item(OP_APPLY, 16'shFF80, 1'b0);
      add_random_phase(300);
      wait_drained();

      write_sample_width(1'b1);
      add_random_phase(300);
      wait_drained();

      // fill the block while the result side holds off
      write_sample_width(1'b0);
      long_hold_request = 1'b1;
      bursty = 1'b0;
      add_random_phase(150);
      wait_drained();
      bursty = 1'b1;

      write_sample_width(1'b1);
      add_random_phase(220);
      wait_drained();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/dcorn_pkg.sv
design/dcorn_if.sv
design/dcorn_div.sv
design/dcorn_ctrl.sv
design/dcorn_datapath.sv
design/dc_offset_remove_normalize_top.sv
design/dcorn_checker.sv
sim/dc_offset_remove_normalize_top_tb.sv
